@@ rtl/pr2d_pkg.sv @@
// constants and arctan table for the 2d point rotator
package pr2d_pkg;

   localparam int COORD_BITS     = 16;
   localparam int ANGLE_BITS     = 16;
   localparam int ROTATION_STEPS = 16;
   localparam int TABLE_LEN      = 24;
   localparam int STEPS          = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
   localparam int GUARD_BITS     = 14;

   // output is one bit wider so the rotated point never saturates
   localparam int OUT_BITS  = COORD_BITS + 1;
   localparam int WORK_BITS = OUT_BITS + GUARD_BITS + 1;

   // cordic gain held as q30, kept in a signed container
   localparam int GAIN_BITS = 31;
   localparam logic signed [GAIN_BITS-1:0] GAIN_Q30 = 31'sd652032874;
   localparam int PRE_SHIFT = 16;
   localparam int PROD_BITS = PRE_SHIFT + WORK_BITS;
   localparam logic signed [PROD_BITS-1:0] PRE_ROUND = PROD_BITS'(1) <<< (PRE_SHIFT - 1);
   localparam logic signed [WORK_BITS-1:0] OUT_ROUND = WORK_BITS'(1) <<< (GUARD_BITS - 1);

   // angle reduction in 1/64 degree units
   localparam int ANGLE_WIDE     = ANGLE_BITS + 1;
   localparam int ANGLE_RES_BITS = 14;
   localparam logic signed [ANGLE_WIDE-1:0] TURN_UNITS          = 17'sd23040;
   localparam logic signed [ANGLE_WIDE-1:0] TWO_TURN_UNITS      = 17'sd46080;
   localparam logic signed [ANGLE_WIDE-1:0] HALF_TURN_UNITS     = 17'sd11520;
   localparam logic signed [ANGLE_WIDE-1:0] QUARTER_UNITS       = 17'sd5760;
   localparam logic signed [ANGLE_WIDE-1:0] THREE_QUARTER_UNITS = 17'sd17280;

   // residual angle in 2^-22 degree units
   localparam int Z_SHIFT = 16;
   localparam int Z_BITS  = 32;

   localparam logic signed [Z_BITS-1:0] ATAN_TABLE [TABLE_LEN] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
      32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
      32'sd229,       32'sd115,       32'sd57,       32'sd29
   };

endpackage

@@ rtl/point_rotation_2d.sv @@
// pipelined cordic rotator for a q7.8 point by an angle in 1/64 degree units
// throughput: one point per cycle while the skid entry is empty; angle fold, gain
// multiply, one stage per micro-rotation, then round into the output register with
// a one-entry skid
// reset clears the valid bits of every stage; data registers are not reset
module point_rotation_2d (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pr2d_pkg::COORD_BITS-1:0] req_x_in,
   input  logic signed [pr2d_pkg::COORD_BITS-1:0] req_y_in,
   input  logic signed [pr2d_pkg::ANGLE_BITS-1:0] req_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pr2d_pkg::OUT_BITS-1:0]   rsp_x_out,
   output logic signed [pr2d_pkg::OUT_BITS-1:0]   rsp_y_out
);

   logic advance;

   // stage 0: angle reduction and half-turn fold
   logic signed [pr2d_pkg::ANGLE_WIDE-1:0] ang_wide;
   logic signed [pr2d_pkg::ANGLE_WIDE-1:0] ang_mod;
   logic signed [pr2d_pkg::ANGLE_WIDE-1:0] ang_fold;
   logic                                   flip;
   logic signed [pr2d_pkg::OUT_BITS-1:0]   x_wide;
   logic signed [pr2d_pkg::OUT_BITS-1:0]   y_wide;
   logic signed [pr2d_pkg::OUT_BITS-1:0]   s0_x_in;
   logic signed [pr2d_pkg::OUT_BITS-1:0]   s0_y_in;

   logic                                       s0_valid_ff;
   logic signed [pr2d_pkg::OUT_BITS-1:0]       s0_x_ff;
   logic signed [pr2d_pkg::OUT_BITS-1:0]       s0_y_ff;
   logic signed [pr2d_pkg::ANGLE_RES_BITS-1:0] s0_ang_ff;

   // stage 1: gain pre-scale
   logic signed [pr2d_pkg::PROD_BITS-1:0] prod_x;
   logic signed [pr2d_pkg::PROD_BITS-1:0] prod_y;

   // cordic stages, index 0 holds the pre-scaled point
   logic                                  cv_in [pr2d_pkg::STEPS+1];
   logic                                  cv_ff [pr2d_pkg::STEPS+1];
   logic signed [pr2d_pkg::WORK_BITS-1:0] cx_in [pr2d_pkg::STEPS+1];
   logic signed [pr2d_pkg::WORK_BITS-1:0] cx_ff [pr2d_pkg::STEPS+1];
   logic signed [pr2d_pkg::WORK_BITS-1:0] cy_in [pr2d_pkg::STEPS+1];
   logic signed [pr2d_pkg::WORK_BITS-1:0] cy_ff [pr2d_pkg::STEPS+1];
   logic signed [pr2d_pkg::Z_BITS-1:0]    cz_in [pr2d_pkg::STEPS+1];
   logic signed [pr2d_pkg::Z_BITS-1:0]    cz_ff [pr2d_pkg::STEPS+1];

   // output rounding, output register and skid entry
   logic signed [pr2d_pkg::WORK_BITS-1:0] round_x;
   logic signed [pr2d_pkg::WORK_BITS-1:0] round_y;
   logic signed [pr2d_pkg::OUT_BITS-1:0]  fin_x;
   logic signed [pr2d_pkg::OUT_BITS-1:0]  fin_y;
   logic                                  fin_valid;

   logic                                  rsp_valid_ff;
   logic signed [pr2d_pkg::OUT_BITS-1:0]  rsp_x_ff;
   logic signed [pr2d_pkg::OUT_BITS-1:0]  rsp_y_ff;
   logic                                  skid_valid_ff;
   logic signed [pr2d_pkg::OUT_BITS-1:0]  skid_x_ff;
   logic signed [pr2d_pkg::OUT_BITS-1:0]  skid_y_ff;

   // the pipeline only holds while the skid entry is occupied
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_comb begin
      ang_wide = pr2d_pkg::ANGLE_WIDE'(req_angle);
      if (ang_wide >= pr2d_pkg::TURN_UNITS) begin
         ang_mod = ang_wide - pr2d_pkg::TURN_UNITS;
      end else if (!ang_wide[pr2d_pkg::ANGLE_WIDE-1]) begin
         ang_mod = ang_wide;
      end else if (ang_wide >= -pr2d_pkg::TURN_UNITS) begin
         ang_mod = ang_wide + pr2d_pkg::TURN_UNITS;
      end else begin
         ang_mod = ang_wide + pr2d_pkg::TWO_TURN_UNITS;
      end

      flip     = 1'b0;
      ang_fold = ang_mod;
      if (ang_mod > pr2d_pkg::THREE_QUARTER_UNITS) begin
         ang_fold = ang_mod - pr2d_pkg::TURN_UNITS;
      end else if (ang_mod > pr2d_pkg::QUARTER_UNITS) begin
         ang_fold = ang_mod - pr2d_pkg::HALF_TURN_UNITS;
         flip     = 1'b1;
      end

      x_wide  = pr2d_pkg::OUT_BITS'(req_x_in);
      y_wide  = pr2d_pkg::OUT_BITS'(req_y_in);
      s0_x_in = flip ? -x_wide : x_wide;
      s0_y_in = flip ? -y_wide : y_wide;
   end

   always_comb begin
      prod_x = (s0_x_ff * pr2d_pkg::GAIN_Q30) + pr2d_pkg::PRE_ROUND;
      prod_y = (s0_y_ff * pr2d_pkg::GAIN_Q30) + pr2d_pkg::PRE_ROUND;

      cv_in[0] = s0_valid_ff;
      cx_in[0] = prod_x[pr2d_pkg::PRE_SHIFT +: pr2d_pkg::WORK_BITS];
      cy_in[0] = prod_y[pr2d_pkg::PRE_SHIFT +: pr2d_pkg::WORK_BITS];
      cz_in[0] = pr2d_pkg::Z_BITS'(s0_ang_ff) <<< pr2d_pkg::Z_SHIFT;

      for (int i = 0; i < pr2d_pkg::STEPS; i++) begin
         cv_in[i+1] = cv_ff[i];
         if (!cz_ff[i][pr2d_pkg::Z_BITS-1]) begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - pr2d_pkg::ATAN_TABLE[i];
         end else begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + pr2d_pkg::ATAN_TABLE[i];
         end
      end
   end

   // round to nearest, ties upward
   always_comb begin
      round_x   = cx_ff[pr2d_pkg::STEPS] + pr2d_pkg::OUT_ROUND;
      round_y   = cy_ff[pr2d_pkg::STEPS] + pr2d_pkg::OUT_ROUND;
      fin_x     = round_x[pr2d_pkg::GUARD_BITS +: pr2d_pkg::OUT_BITS];
      fin_y     = round_y[pr2d_pkg::GUARD_BITS +: pr2d_pkg::OUT_BITS];
      fin_valid = cv_ff[pr2d_pkg::STEPS] && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         for (int i = 0; i <= pr2d_pkg::STEPS; i++) begin
            cv_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         cv_ff       <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_x_ff   <= s0_x_in;
         s0_y_ff   <= s0_y_in;
         s0_ang_ff <= ang_fold[pr2d_pkg::ANGLE_RES_BITS-1:0];
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         cz_ff     <= cz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff  <= skid_valid_ff || fin_valid;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff) begin
         rsp_valid_ff <= fin_valid;
      end else if (fin_valid) begin
         // result waiting and stalled: park the new one
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_x_ff <= skid_x_ff;
            rsp_y_ff <= skid_y_ff;
         end else begin
            rsp_x_ff <= fin_x;
            rsp_y_ff <= fin_y;
         end
      end else if (!rsp_valid_ff) begin
         rsp_x_ff <= fin_x;
         rsp_y_ff <= fin_y;
      end else if (fin_valid) begin
         skid_x_ff <= fin_x;
         skid_y_ff <= fin_y;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_out = rsp_x_ff;
   assign rsp_y_out = rsp_y_ff;

endmodule

@@ sim/tb_point_rotation_2d.sv @@
// self-checking testbench for the pipelined 2d point rotator
`timescale 1ns / 1ps

module tb_point_rotation_2d;

   localparam int CB = pr2d_pkg::COORD_BITS;
   localparam int AB = pr2d_pkg::ANGLE_BITS;
   localparam int OB = pr2d_pkg::OUT_BITS;

   localparam int  CORDIC_STEPS =
      (pr2d_pkg::ROTATION_STEPS > 24) ? 24 : pr2d_pkg::ROTATION_STEPS;
   localparam int  FRAC_GUARD   = 14;
   localparam longint GAIN_K_Q30 = 652032874;
   localparam longint FULL_TURN  = 23040;
   localparam longint HALF_TURN  = 11520;
   localparam longint QUARTER    = 5760;
   localparam longint THREE_QTR  = 17280;

   // arctan(2^-i) in 2^-22 degree units
   localparam longint ATAN_DEG22 [24] = '{
      188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
      3754631, 1877430, 938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29
   };

   localparam int RANDOM_POINTS  = 600;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum logic [1:0] {FOLD_NONE, FOLD_HALF, FOLD_TURN} fold_type;

   typedef struct packed {
      logic                 hold;
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [AB-1:0] angle;
   } point_item_type;

   typedef struct packed {
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic signed [AB-1:0] pa;
      logic signed [OB-1:0] x;
      logic signed [OB-1:0] y;
      fold_type             fold;
   } rotation_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [CB-1:0] req_x_in = '0;
   logic signed [CB-1:0] req_y_in = '0;
   logic signed [AB-1:0] req_angle = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [OB-1:0] rsp_x_out;
   logic signed [OB-1:0] rsp_y_out;

   point_item_type points_to_send [$];
   rotation_type   rotations_due [$];

   logic req_fire = 1'b0;
   int   gap_left = 0;
   int   burst_left = 8;
   int   stall_mode = 0;
   int   stall_phase = 0;
   int   stuck_cycles = 0;
   int   points_accepted = 0;
   int   results_checked = 0;
   int   half_folds = 0;
   int   turn_wraps = 0;
   int   drain_pauses = 0;
   int   mismatches = 0;

   point_rotation_2d DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_x_in  (req_x_in),
      .req_y_in  (req_y_in),
      .req_angle (req_angle),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_x_out (rsp_x_out),
      .rsp_y_out (rsp_y_out)
   );

   always #4 clock = ~clock;

   // gain-compensated cordic rotation, angle folded into [-90, +90] degrees
   function automatic rotation_type cordic_rotate(input logic signed [CB-1:0] px,
                                                  input logic signed [CB-1:0] py,
                                                  input logic signed [AB-1:0] pa);
      longint       x, y, r, z, wx, wy, dx, dy;
      rotation_type res;
      x = px;
      y = py;
      r = pa;
      r = r % FULL_TURN;
      if (r < 0) r = r + FULL_TURN;
      res.px = px;
      res.py = py;
      res.pa = pa;
      res.fold = FOLD_NONE;
      if (r > THREE_QTR) begin
         r = r - FULL_TURN;
         res.fold = FOLD_TURN;
      end else if (r > QUARTER) begin
         r = r - HALF_TURN;
         x = -x;
         y = -y;
         res.fold = FOLD_HALF;
      end
      z = r * 65536;
      wx = (x * GAIN_K_Q30 + 32768) >>> 16;
      wy = (y * GAIN_K_Q30 + 32768) >>> 16;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = wy >>> i;
         dy = wx >>> i;
         if (z >= 0) begin
            wx = wx - dx;
            wy = wy + dy;
            z = z - ATAN_DEG22[i];
         end else begin
            wx = wx + dx;
            wy = wy - dy;
            z = z + ATAN_DEG22[i];
         end
      end
      // round to nearest, ties upwards
      wx = (wx + (longint'(1) << (FRAC_GUARD - 1))) >>> FRAC_GUARD;
      wy = (wy + (longint'(1) << (FRAC_GUARD - 1))) >>> FRAC_GUARD;
      res.x = wx[OB-1:0];
      res.y = wy[OB-1:0];
      return res;
   endfunction

   function automatic logic signed [CB-1:0] pick_coord();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = $urandom;
         2: v = int'($urandom_range(0, 1023)) - 512;
         3: v = ($urandom_range(0, 1) == 1) ? 32767 - int'($urandom_range(0, 3))
                                            : -32768 + int'($urandom_range(0, 3));
         4: v = int'($urandom_range(0, 7)) - 4;
         default: v = ($urandom_range(0, 1) == 1) ? (1 << $urandom_range(0, 14))
                                                  : -(1 << $urandom_range(0, 15));
      endcase
      return v[CB-1:0];
   endfunction

   task automatic queue_point(input int x, input int y, input int a, input logic hold);
      point_item_type item;
      item.hold = hold;
      item.x = x[CB-1:0];
      item.y = y[CB-1:0];
      item.angle = a[AB-1:0];
      points_to_send.push_back(item);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin : driver
      point_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // stalled, payload stays put
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left = gap_left - 1;
      end else if (points_to_send.size() == 0) begin
         req_valid <= 1'b0;
      end else if (points_to_send[0].hold && rotations_due.size() != 0) begin
         // wait for the pipeline to drain completely
         req_valid <= 1'b0;
      end else begin
         item = points_to_send.pop_front();
         if (item.hold) drain_pauses++;
         req_valid <= 1'b1;
         req_x_in  <= item.x;
         req_y_in  <= item.y;
         req_angle <= item.angle;
         burst_left = burst_left - 1;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   // receiver: stall style is re-picked at random among no stalls, light, heavy and periodic stalls
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_phase = stall_phase + 1;
         if (stall_phase % 50 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= (stall_phase % 5) < 3;
         endcase
      end
   end

   always @(posedge clock) begin : monitor
      rotation_type due;
      logic         moved;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         moved = 1'b0;
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (rotations_due.size() == 0) begin
               $display("%0t unexpected result x_out %0d y_out %0d", $time,
                        rsp_x_out, rsp_y_out);
               mismatches++;
            end else begin
               due = rotations_due.pop_front();
               results_checked++;
               if (rsp_x_out !== due.x) begin
                  $display("%0t x_out mismatch (%0d,%0d) angle %0d: expected %0d, actual %0d",
                           $time, due.px, due.py, due.pa, due.x, rsp_x_out);
                  mismatches++;
               end
               if (rsp_y_out !== due.y) begin
                  $display("%0t y_out mismatch (%0d,%0d) angle %0d: expected %0d, actual %0d",
                           $time, due.px, due.py, due.pa, due.y, rsp_y_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            due = cordic_rotate(req_x_in, req_y_in, req_angle);
            rotations_due.push_back(due);
            points_accepted++;
            if (due.fold == FOLD_HALF) half_folds++;
            if (due.fold == FOLD_TURN) turn_wraps++;
         end
         if (moved || (points_to_send.size() == 0 && rotations_due.size() == 0 && !req_valid))
            stuck_cycles = 0;
         else
            stuck_cycles = stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
                     $time, stuck_cycles, rotations_due.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int a;
      // corners of the coordinate range and zero
      queue_point(0, 0, 0, 1'b0);
      queue_point(32767, 32767, 0, 1'b0);
      queue_point(-32768, -32768, 0, 1'b0);
      queue_point(32767, -32768, 1000, 1'b0);
      queue_point(-32768, 32767, -1000, 1'b0);
      // fold boundaries at 90, 180 and 270 degrees
      queue_point(256, 0, 5760, 1'b0);
      queue_point(256, 0, 5761, 1'b0);
      queue_point(-32768, 32767, 11520, 1'b0);
      queue_point(256, 512, 17280, 1'b0);
      queue_point(256, 512, 17281, 1'b0);
      queue_point(32767, 32767, 23039, 1'b0);
      // a whole turn and beyond
      queue_point(1000, -2000, 23040, 1'b0);
      queue_point(1000, -2000, -23040, 1'b0);
      queue_point(-32768, -32768, 32767, 1'b0);
      queue_point(32767, 32767, -32768, 1'b0);
      queue_point(300, 400, -1, 1'b0);
      queue_point(300, 400, -5760, 1'b0);
      queue_point(300, 400, -5761, 1'b0);
      queue_point(-32768, 0, 2880, 1'b0);
      queue_point(0, 32767, 11519, 1'b0);
      queue_point(1, -1, 46079 - 65536, 1'b0);
      for (int n = 0; n < RANDOM_POINTS; n++) begin
         case ($urandom_range(0, 5))
            0, 1: a = int'($urandom_range(0, 65535)) - 32768;
            2: a = (int'($urandom_range(0, 10)) - 5) * 5760 + int'($urandom_range(0, 6)) - 3;
            3: a = int'($urandom_range(0, 360)) * 64 - 11520;
            4: a = $urandom_range(0, 23039);
            default: a = ($urandom_range(0, 1) == 1) ? 32767 - int'($urandom_range(0, 2))
                                                     : -32768 + int'($urandom_range(0, 2));
         endcase
         queue_point(pick_coord(), pick_coord(), a, (n == 0) || (n == 200) || (n == 400));
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (points_to_send.size() != 0 || req_valid || rotations_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d points rotated, %0d results checked, %0d mismatching fields",
               points_accepted, results_checked, mismatches);
      $display("summary: %0d half-turn folds, %0d full-turn wraps, %0d drains of the pipeline",
               half_folds, turn_wraps, drain_pauses);
      if (mismatches == 0 && rotations_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
